FILE: hw/rtl/mpfcb_pkg.sv
// ----------------------------------------------------------------------------
// mpfcb_pkg
// Types and constants shared by the mono pixel fill/copy/blend engine.
// ----------------------------------------------------------------------------
package mpfcb_pkg;

    // Mode codes
    localparam logic [2:0] MODE_FILL   = 3'd0;
    localparam logic [2:0] MODE_COPY1  = 3'd1;
    localparam logic [2:0] MODE_COPY4  = 3'd2;
    localparam logic [2:0] MODE_BLEND1 = 3'd3;
    localparam logic [2:0] MODE_BLEND4 = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_MODE         = 3'd0;
    localparam logic [2:0] CFG_FG_LUM       = 3'd1;
    localparam logic [2:0] CFG_BG_LUM       = 3'd2;
    localparam logic [2:0] CFG_START_PHASE  = 3'd3;
    localparam logic [2:0] CFG_STRIDE_PHASE = 3'd4;
    localparam logic [2:0] CFG_ROW_WIDTH    = 3'd5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Alpha scale and reciprocal for divide by 15 (ceil(65536/15) - 1)
    localparam logic [3:0]  ALPHA_MAX = 4'd15;
    localparam logic [12:0] RECIP15   = 13'd4369;

    // Queue depths
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 4;
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    typedef struct packed {
        logic [7:0] src_byte;
        logic [7:0] dst_pixel;
        logic       restart;
    } t_in;

    typedef struct packed {
        logic [7:0] pixel;
        logic       row_end;
    } t_out;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  fg_lum;
        logic [7:0]  bg_lum;
        logic [2:0]  start_phase;
        logic [2:0]  stride_phase;
        logic [12:0] row_width;
    } t_cfg;

    // Classified pixel passed from front to back
    typedef struct packed {
        logic [2:0] mode;
        logic       bit_sel;
        logic [3:0] nib;
        logic [7:0] dst_pixel;
        logic       row_end;
    } t_work;

endpackage

FILE: hw/rtl/mpfcb_fifo.sv
// ----------------------------------------------------------------------------
// mpfcb_fifo
// Small register queue with show-ahead read data and an occupancy count.
// ----------------------------------------------------------------------------
module mpfcb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic [WIDTH-1:0]               i_wdata,
    output logic                           o_full,
    input  logic                           i_pop,
    output logic [WIDTH-1:0]               o_rdata,
    output logic                           o_empty,
    output logic [$clog2(DEPTH+1)-1:0]     o_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             wr_en, rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_rdata = r_mem[r_rd_ptr];

    assign wr_en = i_push && !o_full;
    assign rd_en = i_pop && !o_empty;

    // Pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

FILE: hw/rtl/mpfcb_front.sv
// ----------------------------------------------------------------------------
// mpfcb_front
// Tracks column and sub-byte phase, picks the source bit or nibble and
// flags the row end for each accepted pixel.
// ----------------------------------------------------------------------------
module mpfcb_front #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mpfcb_pkg::t_cfg    i_cfg,
    input  logic               i_accept,
    input  mpfcb_pkg::t_in     i_in,
    output mpfcb_pkg::t_work   o_work
);

    import mpfcb_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = (CW + 1 > 14) ? CW + 1 : 14;
    localparam logic [WW-1:0] MAX_W = WW'(MAX_WIDTH);

    logic [CW-1:0] r_column, n_column;
    logic [2:0]    r_row_phase, n_row_phase;

    logic [CW-1:0] col_cur;
    logic [2:0]    phase_cur;
    logic [2:0]    pos;
    logic [WW-1:0] rw_ext;
    logic [WW-1:0] eff_w;
    logic          last;

    // Restart applies before this pixel
    assign col_cur   = i_in.restart ? '0 : r_column;
    assign phase_cur = i_in.restart ? i_cfg.start_phase : r_row_phase;
    assign pos       = phase_cur + 3'(col_cur);

    // Effective width: zero counts as one, clamp to the maximum
    assign rw_ext = WW'(i_cfg.row_width);
    always_comb begin
        if (rw_ext == '0) begin
            eff_w = WW'(1);
        end else if (rw_ext > MAX_W) begin
            eff_w = MAX_W;
        end else begin
            eff_w = rw_ext;
        end
    end

    assign last = ((WW'(col_cur) + WW'(1)) >= eff_w);

    // Classified pixel
    always_comb begin
        o_work.mode      = i_cfg.mode;
        o_work.bit_sel   = i_in.src_byte[3'd7 - pos];
        o_work.nib       = pos[0] ? i_in.src_byte[7:4] : i_in.src_byte[3:0];
        o_work.dst_pixel = i_in.dst_pixel;
        o_work.row_end   = last;
    end

    // Column and phase advance
    always_comb begin
        n_column    = r_column;
        n_row_phase = r_row_phase;
        if (i_accept) begin
            n_row_phase = phase_cur;
            if (last) begin
                n_column = '0;
                if (i_cfg.mode inside {MODE_COPY1, MODE_BLEND1}) begin
                    n_row_phase = phase_cur + i_cfg.stride_phase;
                end
            end else begin
                n_column = col_cur + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column    <= '0;
            r_row_phase <= '0;
        end else begin
            r_column    <= n_column;
            r_row_phase <= n_row_phase;
        end
    end

endmodule

FILE: hw/rtl/mpfcb_back.sv
// ----------------------------------------------------------------------------
// mpfcb_back
// Computes the new pixel: selection for fill and 1bpp modes, a weighted
// sum and divide by 15 for 4bpp modes. One register stage; the divide
// settles in front of the result queue.
// ----------------------------------------------------------------------------
module mpfcb_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mpfcb_pkg::t_cfg               i_cfg,
    input  logic                          i_work_valid,
    input  mpfcb_pkg::t_work              i_work,
    output logic                          o_work_pop,
    input  logic [mpfcb_pkg::OUT_CNT_W-1:0] i_out_free,
    output logic                          o_out_push,
    output mpfcb_pkg::t_out               o_out
);

    import mpfcb_pkg::*;

    logic          r_a_valid;
    logic          r_a_mix;
    logic [11:0]   r_a_sum;
    logic [7:0]    r_a_pixel;
    logic          r_a_row_end;

    logic          issue;
    logic          is_mix;
    logic [7:0]    other;
    logic [3:0]    inv_a;
    logic [11:0]   sum;
    logic [7:0]    simple;

    logic [24:0]   recip_prod;
    logic [7:0]    q0;
    logic [11:0]   q0x15;
    logic [11:0]   rem;
    logic [7:0]    quot;

    // Issue only when the result queue has room for everything in flight
    assign issue      = i_work_valid && (i_out_free > OUT_CNT_W'(r_a_valid));
    assign o_work_pop = issue;

    // Stage A: weighted sum or plain selection
    always_comb begin
        is_mix = (i_work.mode == MODE_COPY4) || (i_work.mode == MODE_BLEND4);
        other  = (i_work.mode == MODE_COPY4) ? i_cfg.bg_lum : i_work.dst_pixel;
        inv_a  = ALPHA_MAX - i_work.nib;
        sum    = 12'(i_cfg.fg_lum) * 12'(i_work.nib) + 12'(other) * 12'(inv_a);
        case (i_work.mode)
            MODE_FILL:   simple = i_cfg.fg_lum;
            MODE_COPY1:  simple = i_work.bit_sel ? i_cfg.fg_lum : i_cfg.bg_lum;
            MODE_BLEND1: simple = i_work.bit_sel ? i_cfg.fg_lum : i_work.dst_pixel;
            default:     simple = i_work.dst_pixel;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_a_mix     <= is_mix;
            r_a_sum     <= sum;
            r_a_pixel   <= simple;
            r_a_row_end <= i_work.row_end;
        end
    end

    // Stage B: divide by 15 via reciprocal, one-step correction
    always_comb begin
        recip_prod = 25'(r_a_sum) * 25'(RECIP15);
        q0         = recip_prod[23:16];
        q0x15      = 12'(q0) * 12'(ALPHA_MAX);
        rem        = r_a_sum - q0x15;
        quot       = (rem >= 12'(ALPHA_MAX)) ? q0 + 1'b1 : q0;
    end

    assign o_out_push    = r_a_valid;
    assign o_out.pixel   = r_a_mix ? quot : r_a_pixel;
    assign o_out.row_end = r_a_row_end;

endmodule

FILE: hw/rtl/mono_pixel_fill_copy_blend.sv
// ----------------------------------------------------------------------------
// mono_pixel_fill_copy_blend
// Per-pixel fill / copy / blend engine for an 8-bit grey framebuffer.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue side: drive i_in_data and raise push; a transaction happens
//   on each edge with push high and full low.
//   Result side: while empty is low, o_out_data holds the oldest result;
//   raise pop to take it.
//   Configuration: i_cfg_index / i_cfg_data with i_cfg_valid; o_cfg_ready is
//   always high. Write registers only while no pixel is in flight.
// Path: an accepted pixel passes the front queue and one compute stage register
//   before it is written into the result queue.
// Throughput: one pixel per cycle while pop keeps draining results, fed by the
//   front stage and the one-stage compute pipeline into a 4-entry result queue.
// Reset: queues empty, column and phase zero, registers at their defaults
//   (fill mode, white foreground, black background, width one).
// Stall: when pop stays low the result queue fills, the compute stage stops
//   issuing, the 4-entry front queue fills and full rises; no data is lost.
// ----------------------------------------------------------------------------
module mono_pixel_fill_copy_blend #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Pixel input queue
    input  logic                                push,
    output logic                                full,
    input  mpfcb_pkg::t_in                      i_in_data,
    // Result queue
    output logic                                empty,
    input  logic                                pop,
    output mpfcb_pkg::t_out                     o_out_data,
    // Configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mpfcb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mpfcb_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    import mpfcb_pkg::*;

    localparam int WORK_W = $bits(t_work);
    localparam int OUT_W  = $bits(t_out);

    t_cfg  r_cfg;
    t_work front_work;
    t_work mid_work;
    t_out  back_out;

    logic                      accept;
    logic                      mid_full;
    logic                      mid_empty;
    logic                      mid_pop;
    logic [$clog2(MID_DEPTH+1)-1:0] mid_count;
    logic [WORK_W-1:0]         mid_rdata;
    logic                      out_push;
    logic                      out_full;
    logic [OUT_CNT_W-1:0]      out_count;
    logic [OUT_CNT_W-1:0]      out_free;
    logic [OUT_W-1:0]          out_rdata;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode         <= MODE_FILL;
            r_cfg.fg_lum       <= 8'd255;
            r_cfg.bg_lum       <= 8'd0;
            r_cfg.start_phase  <= 3'd0;
            r_cfg.stride_phase <= 3'd0;
            r_cfg.row_width    <= 13'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MODE:         r_cfg.mode         <= i_cfg_data[2:0];
                CFG_FG_LUM:       r_cfg.fg_lum       <= i_cfg_data[7:0];
                CFG_BG_LUM:       r_cfg.bg_lum       <= i_cfg_data[7:0];
                CFG_START_PHASE:  r_cfg.start_phase  <= i_cfg_data[2:0];
                CFG_STRIDE_PHASE: r_cfg.stride_phase <= i_cfg_data[2:0];
                CFG_ROW_WIDTH:    r_cfg.row_width    <= i_cfg_data[12:0];
                default:          ;
            endcase
        end
    end

    // Front: classify accepted pixels
    assign accept = push && !mid_full;
    assign full   = mid_full;

    mpfcb_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_accept (accept),
        .i_in     (i_in_data),
        .o_work   (front_work)
    );

    // Queue between front and back
    mpfcb_fifo #(
        .WIDTH (WORK_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_wdata (front_work),
        .o_full  (mid_full),
        .i_pop   (mid_pop),
        .o_rdata (mid_rdata),
        .o_empty (mid_empty),
        .o_count (mid_count)
    );

    assign mid_work = t_work'(mid_rdata);

    // Back: compute the pixel
    assign out_free = OUT_CNT_W'(OUT_DEPTH) - out_count;

    mpfcb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_work_valid (!mid_empty && (mid_count != '0)),
        .i_work       (mid_work),
        .o_work_pop   (mid_pop),
        .i_out_free   (out_free),
        .o_out_push   (out_push),
        .o_out        (back_out)
    );

    // Result queue
    mpfcb_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_wdata (back_out),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_rdata (out_rdata),
        .o_empty (empty),
        .o_count (out_count)
    );

    assign o_out_data = (out_full || !out_full) ? t_out'(out_rdata) : '0;

endmodule
